[rtl/core/htach_pkg.sv]
package htach_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 16;
  localparam int COUNT_W  = 16;
  localparam int RPM_W    = 32;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;
  localparam int QDEPTH   = 2;   // power of two
  localparam int DIV_CNT_W = $clog2(RPM_W);

  localparam logic [IDX_W-1:0] REG_WHITE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_BLACK  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd2;

  localparam logic [SAMPLE_W-1:0] WHITE_RST  = 10'd300;
  localparam logic [SAMPLE_W-1:0] BLACK_RST  = 10'd700;
  localparam logic [WIN_W-1:0]    WINDOW_RST = 16'd1000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] white_threshold;
    logic [SAMPLE_W-1:0] black_threshold;
    logic [WIN_W-1:0]    window_ms;
  } htach_cfg_t;

  // one classified sample waiting for the back end
  typedef struct packed {
    logic              rotation_seen;
    logic              rpm_updated;
    logic [RPM_W-1:0]  numer;
    logic [TIME_W-1:0] elapsed;
  } htach_job_t;

  typedef enum logic [1:0] {
    BST_IDLE,
    BST_DIV,
    BST_DONE
  } htach_bst_t;

endpackage

[rtl/core/htach_front.sv]
module htach_front #(
  parameter int MS_PER_MINUTE = 60000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  htach_pkg::htach_cfg_t        cfg,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [htach_pkg::SAMPLE_W-1:0] sensor_sample,
  input  logic [htach_pkg::TIME_W-1:0] now_ms,
  input  logic                         q_full,
  output logic                         q_push,
  output htach_pkg::htach_job_t        q_job
);
  import htach_pkg::*;

  localparam logic [COUNT_W-1:0] MS_C = COUNT_W'(MS_PER_MINUTE);

  logic               armed_r, armed_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;

  logic               is_white, is_black, seen;
  logic [COUNT_W-1:0] count_inc;
  logic [TIME_W-1:0]  elapsed;
  logic               close_win;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    is_white  = sensor_sample <= cfg.white_threshold;
    is_black  = sensor_sample >= cfg.black_threshold;
    // white test wins when thresholds overlap
    seen      = !is_white && is_black && armed_r;
    count_inc = (seen && (count_r != {COUNT_W{1'b1}})) ? count_r + 1'b1 : count_r;
    elapsed   = now_ms - start_r;
    close_win = elapsed > {{(TIME_W-WIN_W){1'b0}}, cfg.window_ms};

    armed_nxt = armed_r;
    count_nxt = count_r;
    start_nxt = start_r;
    if (q_push) begin
      if (is_white) begin
        armed_nxt = 1'b1;
      end else if (seen) begin
        armed_nxt = 1'b0;
      end
      if (close_win) begin
        count_nxt = '0;
        start_nxt = now_ms;
      end else begin
        count_nxt = count_inc;
      end
    end

    q_job.rotation_seen = seen;
    q_job.rpm_updated   = close_win;
    q_job.numer         = {{(RPM_W-COUNT_W){1'b0}}, count_inc} *
                          {{(RPM_W-COUNT_W){1'b0}}, MS_C};
    q_job.elapsed       = elapsed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      count_r <= '0;
      start_r <= '0;
    end else begin
      armed_r <= armed_nxt;
      count_r <= count_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

[rtl/core/htach_fifo.sv]
module htach_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  htach_pkg::htach_job_t push_job,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output htach_pkg::htach_job_t pop_job
);
  import htach_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  htach_job_t          mem_r [QDEPTH];
  logic [PTR_W-1:0]    wptr_r, wptr_nxt;
  logic [PTR_W-1:0]    rptr_r, rptr_nxt;
  logic [PTR_W:0]      fill_r, fill_nxt;

  assign full      = fill_r == (PTR_W+1)'(QDEPTH);
  assign not_empty = fill_r != '0;
  assign pop_job   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

[rtl/core/htach_back.sv]
module htach_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  htach_pkg::htach_job_t        q_job,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [htach_pkg::RPM_W-1:0]  out_rpm,
  output logic                         out_seen,
  output logic                         out_updated
);
  import htach_pkg::*;

  htach_bst_t            state_r, state_nxt;
  logic                  seen_r, seen_nxt;
  logic                  upd_r, upd_nxt;
  logic [RPM_W-1:0]      quo_r, quo_nxt;
  logic [RPM_W-1:0]      rem_r, rem_nxt;
  logic [TIME_W-1:0]     div_r, div_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RPM_W-1:0]      last_rpm_r, last_rpm_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic                  oseen_r, oseen_nxt;
  logic                  oupd_r, oupd_nxt;

  logic [RPM_W:0]        shifted;
  logic [RPM_W+1:0]      trial;

  assign out_tvalid  = ovalid_r;
  assign out_rpm     = last_rpm_r;
  assign out_seen    = oseen_r;
  assign out_updated = oupd_r;

  always_comb begin
    state_nxt    = state_r;
    seen_nxt     = seen_r;
    upd_nxt      = upd_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    div_nxt      = div_r;
    cnt_nxt      = cnt_r;
    last_rpm_nxt = last_rpm_r;
    oseen_nxt    = oseen_r;
    oupd_nxt     = oupd_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    q_pop        = 1'b0;

    // restoring division, one quotient bit per cycle
    shifted = {rem_r, quo_r[RPM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, div_r};

    case (state_r)
      BST_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          seen_nxt  = q_job.rotation_seen;
          upd_nxt   = q_job.rpm_updated;
          quo_nxt   = q_job.numer;
          rem_nxt   = '0;
          div_nxt   = q_job.elapsed;
          cnt_nxt   = '0;
          state_nxt = q_job.rpm_updated ? BST_DIV : BST_DONE;
        end
      end
      BST_DIV: begin
        if (!trial[RPM_W+1]) begin
          rem_nxt = trial[RPM_W-1:0];
          quo_nxt = {quo_r[RPM_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[RPM_W-1:0];
          quo_nxt = {quo_r[RPM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {DIV_CNT_W{1'b1}}) begin
          state_nxt = BST_DONE;
        end
      end
      BST_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oseen_nxt  = seen_r;
          oupd_nxt   = upd_r;
          if (upd_r) begin
            last_rpm_nxt = quo_r;
          end
          state_nxt = BST_IDLE;
        end
      end
      default: begin
        state_nxt = BST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BST_IDLE;
      ovalid_r   <= 1'b0;
      last_rpm_r <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      ovalid_r   <= ovalid_nxt;
      last_rpm_r <= last_rpm_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seen_r  <= seen_nxt;
    upd_r   <= upd_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    oseen_r <= oseen_nxt;
    oupd_r  <= oupd_nxt;
  end

endmodule

[rtl/core/hysteresis_tachometer_rpm.sv]
// Optical tachometer with hysteresis: each input transaction carries one 10-bit
// sensor sample and a millisecond timestamp, and yields exactly one output
// transaction. A sample at or below white_threshold arms the detector; a later
// sample at or above black_threshold counts a rotation (saturating at 65535).
// When the timestamp has moved more than window_ms past the window start, rpm is
// rotations * MS_PER_MINUTE / elapsed, truncated, and the window restarts.
// The front end classifies a sample in its accept cycle and drops it into a
// two-entry queue, so input is taken every cycle until the queue fills. The back
// end drains one entry at a time, passing only window-closing samples through
// the 32-step restoring divider. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce; index 3 is ignored.
module hysteresis_tachometer_rpm #(
  parameter int MS_PER_MINUTE = 60000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [htach_pkg::IDX_W-1:0] cfg_index,
  input  logic [htach_pkg::CFG_W-1:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sensor_sample [9:0], now_ms [41:10], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // rpm_value [31:0]
  output logic [1:0]  out_tuser   // rotation_seen [0], rpm_updated [1]
);
  import htach_pkg::*;

  htach_cfg_t cfg_r, cfg_nxt;
  htach_job_t push_job, pop_job;
  logic       q_full, q_push, q_pop, q_not_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WHITE:  cfg_nxt.white_threshold = cfg_wdata[SAMPLE_W-1:0];
        REG_BLACK:  cfg_nxt.black_threshold = cfg_wdata[SAMPLE_W-1:0];
        REG_WINDOW: cfg_nxt.window_ms       = cfg_wdata[WIN_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_threshold <= WHITE_RST;
      cfg_r.black_threshold <= BLACK_RST;
      cfg_r.window_ms       <= WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  htach_front #(
    .MS_PER_MINUTE(MS_PER_MINUTE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .sensor_sample(in_tdata[SAMPLE_W-1:0]),
    .now_ms       (in_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  htach_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_job  (pop_job)
  );

  htach_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_rpm    (out_tdata),
    .out_seen   (out_tuser[0]),
    .out_updated(out_tuser[1])
  );

endmodule
